[rtl/core/ismic_pkg.sv]
// Package: widths, types and codes shared by the interval set unit.
`timescale 1ns / 1ps
package ismic_pkg;
  localparam int MaxIntervals = 32;
  localparam int CoordWidth = 32;
  localparam int MaxResults = 32;
  localparam int IdxW = $clog2(MaxIntervals);
  localparam int CntW = $clog2(MaxIntervals + 1);
  localparam int SpanW = 2 * CoordWidth;

  typedef logic [1:0] kind_t;
  localparam kind_t KindLoad = 2'd0;
  localparam kind_t KindMerge = 2'd1;
  localparam kind_t KindIntersect = 2'd2;
  localparam kind_t KindComplement = 2'd3;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    kind_t kind;
    logic signed [31:0] lo_bound;
    logic signed [31:0] hi_bound;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_begin;
    logic signed [31:0] out_end;
    logic last_of_run;
    logic list_empty;
    logic overflow_flag;
  } out_word_t;

  // Trim a field to a coordinate.
  function automatic coord_t coord_of(logic [31:0] raw);
    coord_of = coord_t'(raw[CoordWidth-1:0]);
  endfunction

  // Sign extend a coordinate to a field.
  function automatic logic signed [31:0] field_of(coord_t c);
    field_of = 32'(signed'(c));
  endfunction
endpackage

[rtl/core/ismic_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ismic_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and read one entry a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/interval_set_merge_intersect_complement.sv]
// Top level of the interval set unit: sequencer over pending and list RAMs.
`timescale 1ns / 1ps
// One word is worked at a time; the input is taken only while the sequencer is
// idle, and a last result word still waiting in the output register does not
// block it. A load walks the pending list from its end, reading each entry and
// moving it up one place while it starts above the new word; when the pending
// list is full the load is dropped and the sequencer stays idle. Merge,
// intersect and complement walk their source RAM at one entry a cycle, writing
// results into the other list RAM, which then becomes the list, and close in
// a tail state. Each word is then emitted in two steps (read, then load the
// output register), and a receiver stall holds the emit. This pace is set by
// the single registered read port of each RAM. No clearing pass after reset:
// counts alone mark valid entries.
module interval_set_merge_intersect_complement (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ismic_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ismic_pkg::out_word_t  out_data
);
  localparam int IdxW = ismic_pkg::IdxW;
  localparam int CntW = ismic_pkg::CntW;
  localparam int SpanW = ismic_pkg::SpanW;
  localparam int CW = ismic_pkg::CoordWidth;
  localparam logic [CntW-1:0] Full = CntW'(ismic_pkg::MaxIntervals);
  localparam logic [CntW-1:0] MaxRes = CntW'(ismic_pkg::MaxResults);

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StLdRd  = 8'b00000010,
    StLdCmp = 8'b00000100,
    StWalk  = 8'b00001000,
    StTail  = 8'b00010000,
    StEmRd  = 8'b00100000,
    StEmit  = 8'b01000000,
    StEmpty = 8'b10000000
  } state_t;

  state_t state;
  ismic_pkg::kind_t op;
  ismic_pkg::coord_t lo, hi;
  logic [CntW-1:0] pend_cnt, list_cnt, src_cnt, rd_i, wr_n, em_n, em_k;
  logic sel;  // list lives in RAM sel; other RAM is scratch
  logic lost;
  logic have_cur, have_prev;
  ismic_pkg::coord_t cur_b, prev_e;

  // Pending RAM.
  logic p_we;
  logic [IdxW-1:0] p_wa, p_ra;
  logic [SpanW-1:0] p_wd, p_rd;
  ismic_ram #(.Width(SpanW), .Depth(ismic_pkg::MaxIntervals)) u_pend (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  // Two list RAMs, swapped after each rewrite.
  logic l_we [2];
  logic [IdxW-1:0] l_wa [2], l_ra [2];
  logic [SpanW-1:0] l_wd [2], l_rd [2];
  for (genvar g = 0; g < 2; g++) begin : g_list
    ismic_ram #(.Width(SpanW), .Depth(ismic_pkg::MaxIntervals)) u_list (
      .clk(clk), .we(l_we[g]), .waddr(l_wa[g]), .wdata(l_wd[g]),
      .raddr(l_ra[g]), .rdata(l_rd[g]));
  end

  // Source word in flight and its clip to [lo,hi].
  ismic_pkg::coord_t s_b, s_e, c_b, c_e;
  always_comb begin
    if (op == ismic_pkg::KindMerge) begin
      s_b = ismic_pkg::coord_t'(p_rd[SpanW-1:CW]);
      s_e = ismic_pkg::coord_t'(p_rd[CW-1:0]);
    end else begin
      s_b = ismic_pkg::coord_t'(l_rd[sel][SpanW-1:CW]);
      s_e = ismic_pkg::coord_t'(l_rd[sel][CW-1:0]);
    end
    c_b = (s_b > lo) ? s_b : lo;
    c_e = (s_e < hi) ? s_e : hi;
  end

  logic out_fire, in_fire, out_load;
  assign in_fire = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (state != StIdle);
  assign out_load = (state == StEmit || state == StEmpty) && (!out_valid || !out_stall);

  // Walk decisions for the word in flight.
  logic walk_v, keep_v, join_v, gap_v, tail_gap, ld_stop;
  ismic_pkg::coord_t gap_b;
  logic [CntW-1:0] rd_m1;
  assign walk_v = (state == StWalk) && have_cur;
  assign keep_v = c_b < c_e;
  assign join_v = have_prev && (prev_e >= s_b);
  assign gap_v = keep_v && (have_prev || c_b > lo);
  assign gap_b = have_prev ? prev_e : lo;
  assign tail_gap = have_prev && (prev_e < hi);
  assign ld_stop = ismic_pkg::coord_t'(p_rd[SpanW-1:CW]) <= lo;
  assign rd_m1 = rd_i - 1'b1;

  // Scratch write port: at most one result word a cycle.
  logic w_en;
  logic [CntW-1:0] w_at;
  logic [SpanW-1:0] w_dat;
  always_comb begin
    w_en = 1'b0;
    w_at = wr_n;
    w_dat = {cur_b, prev_e};
    case (state)
      StWalk: begin
        if (walk_v) begin
          case (op)
            ismic_pkg::KindMerge: begin
              // close the open run when this word starts a new one
              if (have_prev && !join_v) w_en = 1'b1;
            end
            ismic_pkg::KindIntersect: begin
              if (keep_v) begin
                w_en = 1'b1;
                w_dat = {c_b, c_e};
              end
            end
            default: begin
              // drop gaps beyond capacity
              if (gap_v && wr_n < Full) begin
                w_en = 1'b1;
                w_dat = {gap_b, c_b};
              end
            end
          endcase
        end
      end
      StTail: begin
        case (op)
          ismic_pkg::KindMerge: begin
            if (have_prev) w_en = 1'b1;
          end
          ismic_pkg::KindIntersect: ;
          default: begin
            if (!have_prev) begin
              w_en = 1'b1;
              w_at = '0;
              w_dat = {lo, hi};
            end else if (tail_gap && wr_n < Full) begin
              w_en = 1'b1;
              w_dat = {prev_e, hi};
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // Route the scratch write and the shared read address.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      l_wa[g] = w_at[IdxW-1:0];
      l_wd[g] = w_dat;
      l_ra[g] = (state == StEmRd || state == StEmit) ? em_k[IdxW-1:0] : rd_i[IdxW-1:0];
    end
    l_we[0] = w_en && sel;
    l_we[1] = w_en && !sel;
  end

  // Pending RAM: sorted insert by shifting from the end.
  always_comb begin
    p_we = 1'b0;
    p_wa = rd_i[IdxW-1:0];
    p_wd = {lo, hi};
    p_ra = rd_i[IdxW-1:0];
    case (state)
      StLdRd: begin
        if (rd_i == '0) begin
          p_we = 1'b1;
        end else begin
          p_ra = rd_m1[IdxW-1:0];
        end
      end
      StLdCmp: begin
        // p_rd holds entry rd_i-1: place the new word or move the entry up
        p_we = 1'b1;
        if (!ld_stop) p_wd = p_rd;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      pend_cnt <= '0;
      list_cnt <= '0;
      lost <= 1'b0;
      sel <= 1'b0;
      out_valid <= 1'b0;
      have_cur <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (in_fire) begin
            op <= in_data.kind;
            lo <= ismic_pkg::coord_of(in_data.lo_bound);
            hi <= ismic_pkg::coord_of(in_data.hi_bound);
            have_cur <= 1'b0;
            have_prev <= 1'b0;
            wr_n <= '0;
            if (in_data.kind == ismic_pkg::KindLoad) begin
              rd_i <= pend_cnt;
              if (pend_cnt >= Full) begin
                lost <= 1'b1;
              end else begin
                state <= StLdRd;
              end
            end else begin
              rd_i <= '0;
              src_cnt <= (in_data.kind == ismic_pkg::KindMerge) ? pend_cnt : list_cnt;
              state <= StWalk;
            end
          end
        end
        StLdRd: begin
          if (rd_i == '0) begin
            pend_cnt <= pend_cnt + 1'b1;
            state <= StIdle;
          end else begin
            state <= StLdCmp;
          end
        end
        StLdCmp: begin
          if (ld_stop) begin
            pend_cnt <= pend_cnt + 1'b1;
            state <= StIdle;
          end else begin
            rd_i <= rd_m1;
            state <= StLdRd;
          end
        end
        StWalk: begin
          if (rd_i < src_cnt) rd_i <= rd_i + 1'b1;
          have_cur <= (rd_i < src_cnt);
          if (walk_v) begin
            case (op)
              ismic_pkg::KindMerge: begin
                if (join_v) begin
                  if (prev_e < s_e) prev_e <= s_e;
                end else begin
                  cur_b <= s_b;
                  prev_e <= s_e;
                  have_prev <= 1'b1;
                  if (have_prev) wr_n <= wr_n + 1'b1;
                end
              end
              ismic_pkg::KindIntersect: begin
                if (keep_v) wr_n <= wr_n + 1'b1;
              end
              default: begin
                // complement: gaps between clipped survivors
                if (keep_v) begin
                  if (gap_v) begin
                    wr_n <= wr_n + 1'b1;
                    if (wr_n >= Full) lost <= 1'b1;
                  end
                  have_prev <= 1'b1;
                  prev_e <= c_e;
                end
              end
            endcase
          end
          if (rd_i == src_cnt) state <= StTail;
        end
        StTail: begin
          sel <= !sel;
          em_k <= '0;
          state <= StEmRd;
          case (op)
            ismic_pkg::KindMerge: begin
              list_cnt <= have_prev ? wr_n + 1'b1 : '0;
              pend_cnt <= '0;
            end
            ismic_pkg::KindIntersect: begin
              list_cnt <= wr_n;
            end
            default: begin
              if (!have_prev) begin
                list_cnt <= CntW'(1);
              end else if (tail_gap) begin
                list_cnt <= (wr_n >= Full) ? Full : wr_n + 1'b1;
                if (wr_n >= Full) lost <= 1'b1;
              end else begin
                list_cnt <= (wr_n > Full) ? Full : wr_n;
              end
            end
          endcase
        end
        StEmRd: begin
          em_n <= (list_cnt > MaxRes) ? MaxRes : list_cnt;
          state <= (list_cnt == '0) ? StEmpty : StEmit;
        end
        StEmit: begin
          if (out_load) begin
            out_data.out_begin <= ismic_pkg::field_of(
              ismic_pkg::coord_t'(l_rd[sel][SpanW-1:CW]));
            out_data.out_end <= ismic_pkg::field_of(ismic_pkg::coord_t'(l_rd[sel][CW-1:0]));
            out_data.last_of_run <= (em_k + 1'b1 == em_n);
            out_data.list_empty <= 1'b0;
            out_data.overflow_flag <= lost;
            em_k <= em_k + 1'b1;
            if (em_k + 1'b1 == em_n) begin
              lost <= 1'b0;
              state <= StIdle;
            end else begin
              state <= StEmRd;
            end
          end
        end
        StEmpty: begin
          if (out_load) begin
            out_data <= '{out_begin: '0, out_end: '0, last_of_run: 1'b1,
                          list_empty: 1'b1, overflow_flag: lost};
            lost <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Checks.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> in_stall) else $error("input taken while busy");
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= Full) else $error("pending count beyond capacity");
  a_list_max: assert property (@(posedge clk) disable iff (rst)
    list_cnt <= Full) else $error("list count beyond capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("word dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("stalled word changed");
endmodule

[tb/sv/interval_set_checker.sv]
// Checker for the interval set unit: predicts list results and compares output words.
`timescale 1ns / 1ps
module interval_set_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ismic_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ismic_pkg::out_word_t out_data,
  output int                   fail_count,
  output int                   words_waiting
);
  typedef struct {
    longint b;
    longint e;
  } span_t;

  span_t                pend_q[$];
  span_t                list_q[$];
  bit                   lost;
  ismic_pkg::out_word_t expected_words[$];

  function automatic longint trim(logic [31:0] raw);
    logic signed [ismic_pkg::CoordWidth-1:0] c;
    c = raw[ismic_pkg::CoordWidth-1:0];
    return longint'(c);
  endfunction

  // Clip every listed span to [lo,hi], drop empty ones.
  function automatic void clip_spans(longint lo, longint hi);
    span_t kept[$];
    span_t s;
    foreach (list_q[i]) begin
      s.b = list_q[i].b > lo ? list_q[i].b : lo;
      s.e = list_q[i].e < hi ? list_q[i].e : hi;
      if (s.b < s.e) kept.insert(kept.size(), s);
    end
    list_q = kept;
  endfunction

  function automatic void push_gap(ref span_t gaps[$], input longint b, longint e);
    span_t s;
    if (gaps.size() >= ismic_pkg::MaxIntervals) begin
      lost = 1'b1;
      return;
    end
    s.b = b;
    s.e = e;
    gaps.insert(gaps.size(), s);
  endfunction

  // Apply one accepted word and queue the words it should produce.
  function automatic void predict_word(ismic_pkg::in_word_t w);
    longint lo, hi;
    int pos, n;
    span_t s;
    span_t gaps[$];
    ismic_pkg::out_word_t r;
    lo = trim(w.lo_bound);
    hi = trim(w.hi_bound);
    case (w.kind)
      ismic_pkg::KindLoad: begin
        if (pend_q.size() >= ismic_pkg::MaxIntervals) begin
          lost = 1'b1;
        end else begin
          pos = 0;
          while (pos < pend_q.size() && pend_q[pos].b <= lo) pos++;
          s.b = lo;
          s.e = hi;
          pend_q.insert(pos, s);
        end
        return;
      end
      ismic_pkg::KindMerge: begin
        list_q.delete();
        foreach (pend_q[i]) begin
          if (list_q.size() > 0 && list_q[$].e >= pend_q[i].b) begin
            if (list_q[$].e < pend_q[i].e) list_q[$].e = pend_q[i].e;
          end else begin
            list_q.insert(list_q.size(), pend_q[i]);
          end
        end
        pend_q.delete();
      end
      ismic_pkg::KindIntersect: clip_spans(lo, hi);
      default: begin
        if (list_q.size() > 0) clip_spans(lo, hi);
        if (list_q.size() == 0) begin
          s.b = lo;
          s.e = hi;
          list_q.insert(0, s);
        end else begin
          if (list_q[0].b > lo) push_gap(gaps, lo, list_q[0].b);
          for (int i = 0; i + 1 < list_q.size(); i++)
            push_gap(gaps, list_q[i].e, list_q[i+1].b);
          if (list_q[$].e < hi) push_gap(gaps, list_q[$].e, hi);
          list_q = gaps;
        end
      end
    endcase
    // Emit the list, or the empty marker.
    n = list_q.size() < ismic_pkg::MaxResults ? list_q.size() : ismic_pkg::MaxResults;
    if (n == 0) begin
      r = '0;
      r.last_of_run = 1'b1;
      r.list_empty = 1'b1;
      r.overflow_flag = lost;
      expected_words.insert(expected_words.size(), r);
    end
    for (int k = 0; k < n; k++) begin
      r.out_begin = list_q[k].b[31:0];
      r.out_end = list_q[k].e[31:0];
      r.last_of_run = (k + 1 == n);
      r.list_empty = 1'b0;
      r.overflow_flag = lost;
      expected_words.insert(expected_words.size(), r);
    end
    lost = 1'b0;
  endfunction

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    ismic_pkg::out_word_t want;
    if (rst) begin
      pend_q.delete();
      list_q.delete();
      expected_words.delete();
      lost = 1'b0;
      fail_count <= 0;
      words_waiting <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (out_data !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_data);
      words_waiting <= expected_words.size();
    end
  end
endmodule

[tb/sv/tb.sv]
// Testbench top for the interval set unit: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb;
  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 600;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  ismic_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  ismic_pkg::out_word_t out_data;
  int                   fail_count;
  int                   words_waiting;
  int                   send_idle_pct;
  int                   stall_pct;
  bit                   hold_off;
  int                   idle_cycles;

  interval_set_merge_intersect_complement dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  interval_set_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .words_waiting(words_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive receiver stall at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // Long hold-off of the receiver, counted here.
  task automatic hold_receiver();
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(negedge clk);
    hold_off = 1'b0;
  endtask

  // Watchdog: cycles with no accepted word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one word at the falling edge; hold it until accepted.
  task automatic send_word(ismic_pkg::kind_t k, logic [31:0] lo, logic [31:0] hi);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, lo_bound: lo, hi_bound: hi};
    taken = 1'b0;
    while (!taken) begin
      // stall is settled here and holds until the next rising edge
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom;
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  // A load sequence of random length followed by a merge and up to three intersect or complement operations.
  task automatic random_group();
    int n;
    logic [31:0] a, b;
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    repeat (n) begin
      a = rand_coord();
      b = ($urandom_range(5) == 0) ? rand_coord() : a + $urandom_range(30);
      send_word(ismic_pkg::KindLoad, a, b);
    end
    send_word(ismic_pkg::KindMerge, $urandom, $urandom);
    repeat ($urandom_range(3)) begin
      a = rand_coord();
      b = ($urandom_range(4) == 0) ? rand_coord() : a + $urandom_range(150);
      send_word($urandom_range(1) ? ismic_pkg::KindIntersect : ismic_pkg::KindComplement,
                a, b);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: empty list ops, extremes, touching, inverted, overflow.
    send_word(ismic_pkg::KindMerge, 0, 0);
    send_word(ismic_pkg::KindIntersect, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ismic_pkg::KindComplement, 32'h8000_0000, 32'h7fff_ffff);
    send_word(ismic_pkg::KindComplement, 10, 20);
    send_word(ismic_pkg::KindLoad, 5, 10);
    send_word(ismic_pkg::KindLoad, 10, 15);
    send_word(ismic_pkg::KindLoad, 30, 20);
    send_word(ismic_pkg::KindLoad, 32'h8000_0000, 32'h8000_0005);
    send_word(ismic_pkg::KindLoad, 32'h7fff_fff0, 32'h7fff_ffff);
    send_word(ismic_pkg::KindMerge, 0, 0);
    send_word(ismic_pkg::KindIntersect, 0, 100);
    send_word(ismic_pkg::KindComplement, 0, 100);
    send_word(ismic_pkg::KindIntersect, 200, 300);
    send_word(ismic_pkg::KindComplement, 32'hffff_ffff, 32'h0000_0000);
    for (int i = 0; i < 34; i++) send_word(ismic_pkg::KindLoad, 4 * i, 4 * i + 1);
    send_word(ismic_pkg::KindMerge, 0, 0);
    send_word(ismic_pkg::KindComplement, 32'hffff_fff0, 200);

    // Random phases of idling.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 61 : 17) : 0;
      stall_pct = (p == 2 || p == 3) ? (p == 2 ? 61 : 17) : 0;
      if (p == 0) fork hold_receiver(); join_none
      repeat (13) random_group();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;

    while (words_waiting != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/ismic_pkg.sv
rtl/core/ismic_ram.sv
rtl/core/interval_set_merge_intersect_complement.sv
tb/sv/interval_set_checker.sv
tb/sv/tb.sv
